// ===== hw/rtl/http_chunked_decoder_macros.svh =====
// assertion helpers shared by the chunked decoder rtl
`ifndef HTTP_CHUNKED_DECODER_MACROS_SVH
`define HTTP_CHUNKED_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define HCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_pkg
// Types, constants and helper functions for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

   localparam int MAX_LINE  = 1024;
   localparam int SIZE_BITS = 32;
   localparam int LINE_BITS = $clog2(MAX_LINE);

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_DATA,
      PH_AFTER,
      PH_TRAILER,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_DECODING = 2'd0,
      STATUS_FINISHED = 2'd1,
      STATUS_STOPPED  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_LINE_LONG = 2'd1,
      ERR_BAD_SIZE  = 2'd2,
      ERR_GARBAGE   = 2'd3
   } err_kind_type;

   // space, tab, lf, vt, ff, cr
   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
             (c == 8'h0C) || (c == 8'h0D);
   endfunction

   // {is_hex, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic [7:0] ok_char(input logic [1:0] pos);
      logic [7:0] r;
      r = CHAR_LF;
      case (pos)
         2'd0:    r = 8'h4F;
         2'd1:    r = 8'h4B;
         default: r = CHAR_LF;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/http_chunked_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_decoder
// Decodes an HTTP/1.1 chunked body one byte per transfer.
// ----------------------------------------------------------------------------
// Usage: body bytes enter on req_rx_byte with a req_valid/req_ready transfer.
// Every accepted byte yields exactly one result on the rsp_ channel: the byte
// itself when it was chunk data (rsp_payload_valid set, else byte reads 0),
// the decode status (decoding, finished, stopped on error), the error kind and
// whether the payload so far is exactly "OK\n".
// The result of a byte is registered at the edge that accepts it and shows on
// rsp_ in the next cycle. Throughput is one byte per cycle while the receiver
// keeps up; the decode state update is a single pass of logic per byte.
// When the receiver stalls, the result register holds and req_ready drops
// until the pending result is taken; a transfer on both sides in one cycle
// keeps the stream at full rate.
// Synchronous reset returns to the start of a size line with no result
// pending. After finish or error, further bytes are accepted and ignored and
// the status is held.
// ----------------------------------------------------------------------------
`include "http_chunked_decoder_macros.svh"

module http_chunked_decoder
   import hcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_payload_valid,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_error_kind,
   output logic       rsp_ok_match
);

   localparam logic [LINE_BITS-1:0] LINE_LIMIT = LINE_BITS'(MAX_LINE - 2);

   phase_type             phase_ff, phase_in;
   logic [LINE_BITS-1:0]  line_count_ff, line_count_in;
   logic [SIZE_BITS-1:0]  remaining_ff, remaining_in;
   logic [SIZE_BITS-1:0]  size_accum_ff, size_accum_in;
   logic                  dig_ff, dig_in;
   logic                  done_ff, done_in;
   logic                  mark_ff, mark_in;
   err_kind_type          err_kind_ff, err_kind_in;
   logic [1:0]            match_cnt_ff, match_cnt_in;
   logic                  match_fail_ff, match_fail_in;

   logic                  rsp_valid_ff;
   logic [7:0]            payload_byte_ff, payload_byte_in;
   logic                  payload_valid_ff, payload_valid_in;
   status_type            status_ff, status_in;
   err_kind_type          error_kind_ff, error_kind_in;
   logic                  ok_match_ff, ok_match_in;

   logic                  req_fire;
   logic [7:0]            c;
   logic [4:0]            hex;
   logic                  c_ws, c_lf, c_cr;
   logic [SIZE_BITS-1:0]  remaining_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign c             = req_rx_byte;
   assign hex           = hex_digit(c);
   assign c_ws          = is_ws(c);
   assign c_lf          = (c == CHAR_LF);
   assign c_cr          = (c == CHAR_CR);
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - 1'b1 : remaining_ff;

   // next state
   always_comb begin
      phase_in      = phase_ff;
      line_count_in = line_count_ff;
      remaining_in  = remaining_ff;
      size_accum_in = size_accum_ff;
      dig_in        = dig_ff;
      done_in       = done_ff;
      mark_in       = mark_ff;
      err_kind_in   = err_kind_ff;
      match_cnt_in  = match_cnt_ff;
      match_fail_in = match_fail_ff;

      unique case (phase_ff)
         PH_DATA: begin
            if (!match_fail_ff) begin
               if (match_cnt_ff == 2'd3 || c != ok_char(match_cnt_ff)) begin
                  match_fail_in = 1'b1;
                  match_cnt_in  = 2'd0;
               end else begin
                  match_cnt_in = match_cnt_ff + 2'd1;
               end
            end
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               phase_in      = PH_AFTER;
               line_count_in = '0;
               size_accum_in = '0;
               dig_in        = 1'b0;
               done_in       = 1'b0;
               mark_in       = 1'b0;
            end
         end
         PH_SIZE, PH_AFTER, PH_TRAILER: begin
            if (!c_lf && line_count_ff >= LINE_LIMIT) begin
               phase_in    = PH_ERROR;
               err_kind_in = ERR_LINE_LONG;
            end else if (!c_lf) begin
               line_count_in = line_count_ff + 1'b1;
               if (phase_ff == PH_SIZE) begin
                  if (done_ff || mark_ff) begin
                     // rest of the size line is ignored
                  end else if (dig_ff) begin
                     if (hex[4]) begin
                        if (size_accum_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                           size_accum_in = '1;
                        end else begin
                           size_accum_in = {size_accum_ff[SIZE_BITS-5:0], hex[3:0]};
                        end
                     end else if (c_ws) begin
                        done_in = 1'b1;
                     end else begin
                        mark_in = 1'b1;
                     end
                  end else if (hex[4]) begin
                     dig_in        = 1'b1;
                     size_accum_in = {{(SIZE_BITS-4){1'b0}}, hex[3:0]};
                  end else if (line_count_ff == '0) begin
                     if (!c_ws) mark_in = 1'b1;
                  end else if (!c_ws) begin
                     // leading whitespace then junk: size line reads as zero
                     done_in = 1'b1;
                  end
               end else if (line_count_ff != '0 || !c_cr) begin
                  mark_in = 1'b1;
               end
            end else begin
               line_count_in = '0;
               size_accum_in = '0;
               dig_in        = 1'b0;
               done_in       = 1'b0;
               mark_in       = 1'b0;
               if (phase_ff == PH_SIZE) begin
                  if (mark_ff) begin
                     phase_in    = PH_ERROR;
                     err_kind_in = ERR_BAD_SIZE;
                  end else if (size_accum_ff == '0) begin
                     phase_in = PH_TRAILER;
                  end else begin
                     phase_in     = PH_DATA;
                     remaining_in = size_accum_ff;
                  end
               end else if (phase_ff == PH_AFTER) begin
                  if (mark_ff) begin
                     phase_in    = PH_ERROR;
                     err_kind_in = ERR_GARBAGE;
                  end else begin
                     phase_in = PH_SIZE;
                  end
               end else if (!mark_ff) begin
                  phase_in = PH_DONE;
               end
            end
         end
         PH_DONE, PH_ERROR: begin
            // input ignored
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

   // result fields
   always_comb begin
      payload_valid_in = (phase_ff == PH_DATA);
      payload_byte_in  = payload_valid_in ? c : 8'd0;
      status_in        = STATUS_DECODING;
      error_kind_in    = ERR_NONE;
      unique case (phase_in)
         PH_DONE:  status_in = STATUS_FINISHED;
         PH_ERROR: begin
            status_in     = STATUS_STOPPED;
            error_kind_in = err_kind_in;
         end
         default:  status_in = STATUS_DECODING;
      endcase
      ok_match_in = !match_fail_in && (match_cnt_in == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         line_count_ff <= '0;
         remaining_ff  <= '0;
         size_accum_ff <= '0;
         dig_ff        <= 1'b0;
         done_ff       <= 1'b0;
         mark_ff       <= 1'b0;
         err_kind_ff   <= ERR_NONE;
         match_cnt_ff  <= 2'd0;
         match_fail_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff      <= phase_in;
            line_count_ff <= line_count_in;
            remaining_ff  <= remaining_in;
            size_accum_ff <= size_accum_in;
            dig_ff        <= dig_in;
            done_ff       <= done_in;
            mark_ff       <= mark_in;
            err_kind_ff   <= err_kind_in;
            match_cnt_ff  <= match_cnt_in;
            match_fail_ff <= match_fail_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         payload_byte_ff  <= payload_byte_in;
         payload_valid_ff <= payload_valid_in;
         status_ff        <= status_in;
         error_kind_ff    <= error_kind_in;
         ok_match_ff      <= ok_match_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = payload_byte_ff;
   assign rsp_payload_valid = payload_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_error_kind    = error_kind_ff;
   assign rsp_ok_match      = ok_match_ff;

   `HCD_ASSERT_NOW(a_data_while_decoding, clock, reset,
      rsp_valid && rsp_payload_valid, rsp_status == STATUS_DECODING,
      "data byte reported with a final status")

   `HCD_ASSERT_NOW(a_error_kind_only_on_stop, clock, reset,
      rsp_valid && rsp_status != STATUS_STOPPED, rsp_error_kind == ERR_NONE,
      "error kind set without a stop")

   `HCD_ASSERT_NOW(a_stop_has_kind, clock, reset,
      rsp_valid && rsp_status == STATUS_STOPPED, rsp_error_kind != ERR_NONE,
      "stop reported without an error kind")

   `HCD_ASSERT_NEXT(a_done_sticky, clock, reset,
      phase_ff == PH_DONE || phase_ff == PH_ERROR, $stable(phase_ff),
      "finished or stopped decoder left its final phase")
endmodule
